@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker file psu_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/psu_pkg.sv @@
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types, codes and the Paeth helper function of the PNG scanline unfilter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psu_pkg;

   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA  = 2'd2;

   localparam logic [2:0] FILT_NONE  = 3'd0;
   localparam logic [2:0] FILT_SUB   = 3'd1;
   localparam logic [2:0] FILT_UP    = 3'd2;
   localparam logic [2:0] FILT_AVG   = 3'd3;
   localparam logic [2:0] FILT_PAETH = 3'd4;
   localparam logic [2:0] FILT_BAD   = 3'd7;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   localparam int OQ_DEPTH = 4;
   localparam int OQ_PTR_W = 2;
   localparam int OQ_CNT_W = 3;

   typedef struct packed {
      logic       is_filter;
      logic       err;
      logic       discard;
      logic [2:0] kind;
      logic [1:0] ch;
      logic       pix_done;
      logic       last;
      logic       has_alpha;
      logic       up_ok;
      logic       wr_ok;
   } stage_ctl_type;

   typedef struct packed {
      logic [31:0] pixel;
      logic        last;
      logic        bad;
   } rsp_beat_type;

   function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
      logic signed [9:0] da;
      logic signed [9:0] db;
      logic signed [9:0] dc;
      logic [9:0]        pa;
      logic [9:0]        pb;
      logic [9:0]        pc;
      da = $signed({2'b00, b}) - $signed({2'b00, c});
      db = $signed({2'b00, a}) - $signed({2'b00, c});
      dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
      pa = da[9] ? 10'(-da) : 10'(da);
      pb = db[9] ? 10'(-db) : 10'(db);
      pc = dc[9] ? 10'(-dc) : 10'(dc);
      if (pa <= pb && pa <= pc) begin
         return a;
      end else if (pb <= pc) begin
         return b;
      end
      return c;
   endfunction

endpackage

@@ hdl/psu_line_store.sv @@
// ----------------------------------------------------------------------------
// psu_line_store
// Previous-row byte store: one write port, one registered read port,
// write data forwarded on a same-address collision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psu_line_store #(
   parameter int DEPTH = 4096,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= (wr_en && wr_addr == rd_addr) ? wr_data : mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/psu_out_fifo.sv @@
// ----------------------------------------------------------------------------
// psu_out_fifo
// Small result queue between the reconstruction stage and the rsp channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psu_out_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  psu_pkg::rsp_beat_type         push_beat,
   output logic                          out_valid,
   input  logic                          out_ready,
   output psu_pkg::rsp_beat_type         out_beat,
   output logic [psu_pkg::OQ_CNT_W-1:0]  fill
);

   localparam int PTR_W = psu_pkg::OQ_PTR_W;
   localparam int CNT_W = psu_pkg::OQ_CNT_W;

   psu_pkg::rsp_beat_type entries [psu_pkg::OQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             pop;

   assign out_valid = (cnt_ff != '0);
   assign pop       = out_valid && out_ready;
   assign out_beat  = entries[rd_ptr_ff];
   assign fill      = cnt_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         unique case ({push, pop})
            2'b10:   cnt_ff <= cnt_ff + CNT_W'(1);
            2'b01:   cnt_ff <= cnt_ff - CNT_W'(1);
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

endmodule

@@ hdl/png_scanline_unfilter_bgra_unit.sv @@
// ----------------------------------------------------------------------------
// png_scanline_unfilter_bgra_unit
// PNG row filter reconstruction (None/Sub/Up/Average/Paeth) for 8-bit RGB
// and RGBA, emitting one BGRA8888 word per completed pixel.
//
// req channel: one inflated byte per beat; a row is one filter byte then
//    width*3 (RGB) or width*4 (RGBA) sample bytes.
// rsp channel: one beat per finished pixel; last_of_image marks the final
//    pixel of the image. A filter byte above 4 gives a single beat with
//    bad_filter and last_of_image set and pixel zero; the rest of that
//    image is consumed without beats.
// csr port: width_pixels, height_rows, has_alpha; write while idle.
// Throughput: one byte per cycle while req_ready is high. The line
//    store read issued on accept returns in the next cycle, in stage B,
//    where the byte is reconstructed against the left pixel register
//    that closes the left-byte feedback loop.
// Output path: stage B pushes each finished pixel's beat into the queue.
// Stall: a four-entry result queue absorbs rsp backpressure; req_ready
//    drops when the queue could not hold the bytes in flight.
// Reset clears position, row count and queue; the line store is not
//    cleared (row 0 ignores its read data).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module png_scanline_unfilter_bgra_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int LINE_BYTES = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_data_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [31:0]                       rsp_pixel_bgra,
   output logic                              rsp_last_of_image,
   output logic                              rsp_bad_filter,
   input  logic                              csr_we,
   input  logic [psu_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [psu_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int ADDR_W = $clog2(LINE_BYTES);
   localparam int ROWB_W = $clog2(MAX_WIDTH * 4 + 1);
   localparam int CNT_W  = psu_pkg::OQ_CNT_W;

   // configuration
   logic [10:0] width_ff;
   logic [15:0] height_ff;
   logic        alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd1;
         height_ff <= 16'd1;
         alpha_ff  <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            psu_pkg::CSR_WIDTH:  width_ff  <= csr_wdata[10:0];
            psu_pkg::CSR_HEIGHT: height_ff <= csr_wdata[15:0];
            psu_pkg::CSR_ALPHA:  alpha_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic [31:0]       w_lim;
   logic [ROWB_W-1:0] row_len;
   logic [15:0]       h_eff;

   always_comb begin
      w_lim = 32'(width_ff);
      if (w_lim == 32'd0) begin
         w_lim = 32'd1;
      end else if (w_lim > 32'(MAX_WIDTH)) begin
         w_lim = 32'(MAX_WIDTH);
      end
      row_len = alpha_ff ? ROWB_W'(w_lim << 2) : ROWB_W'((w_lim << 1) + w_lim);
      h_eff   = (height_ff == 16'd0) ? 16'd1 : height_ff;
   end

   // stage A: byte position and row tracking, line store read
   logic [ROWB_W-1:0] pos_ff;
   logic [15:0]       row_ff;
   logic [2:0]        kind_ff;
   logic              disc_ff;
   logic [1:0]        ch3_ff;

   logic                  accept;
   logic                  is_filter;
   logic                  bad;
   logic [ROWB_W-1:0]     idx;
   logic [31:0]           idx32;
   logic                  in_range;
   logic                  row_end;
   logic                  last_row;
   logic [1:0]            ch;
   logic [ADDR_W-1:0]     rd_addr;
   psu_pkg::stage_ctl_type ctl_a;

   assign accept    = req_valid && req_ready;
   assign is_filter = (pos_ff == '0);
   assign bad       = req_data_byte > {5'd0, psu_pkg::FILT_PAETH};
   assign idx       = pos_ff - ROWB_W'(1);
   assign idx32     = 32'(idx);
   assign in_range  = idx32 < 32'(LINE_BYTES);
   assign rd_addr   = idx32[ADDR_W-1:0];
   assign row_end   = pos_ff >= row_len;
   assign last_row  = ({1'b0, row_ff} + 17'd1) >= {1'b0, h_eff};
   assign ch        = alpha_ff ? idx[1:0] : ch3_ff;

   always_comb begin
      ctl_a.is_filter = is_filter;
      ctl_a.err       = is_filter && bad && !disc_ff;
      ctl_a.discard   = disc_ff;
      ctl_a.kind      = kind_ff;
      ctl_a.ch        = ch;
      ctl_a.pix_done  = alpha_ff ? (ch == 2'd3) : (ch == 2'd2);
      ctl_a.last      = row_end && last_row;
      ctl_a.has_alpha = alpha_ff;
      ctl_a.up_ok     = (row_ff != 16'd0) && in_range;
      ctl_a.wr_ok     = in_range;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         row_ff  <= '0;
         kind_ff <= psu_pkg::FILT_NONE;
         disc_ff <= 1'b0;
         ch3_ff  <= 2'd0;
      end else if (accept) begin
         if (is_filter) begin
            kind_ff <= bad ? psu_pkg::FILT_BAD : req_data_byte[2:0];
            pos_ff  <= ROWB_W'(1);
            ch3_ff  <= 2'd0;
            if (bad) begin
               disc_ff <= 1'b1;
            end
         end else begin
            ch3_ff <= (ch3_ff == 2'd2) ? 2'd0 : ch3_ff + 2'd1;
            if (row_end) begin
               pos_ff <= '0;
               if (last_row) begin
                  row_ff  <= '0;
                  disc_ff <= 1'b0;
               end else begin
                  row_ff <= row_ff + 16'd1;
               end
            end else begin
               pos_ff <= pos_ff + ROWB_W'(1);
            end
         end
      end
   end

   // stage B: reconstruction
   logic                   b_valid_ff;
   logic [7:0]             b_byte_ff;
   logic [ADDR_W-1:0]      b_addr_ff;
   psu_pkg::stage_ctl_type b_ctl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_byte_ff <= req_data_byte;
         b_addr_ff <= rd_addr;
         b_ctl_ff  <= ctl_a;
      end
   end

   logic [7:0] rd_data;
   logic       wr_en;
   logic [7:0] up;
   logic [4:0] sh;
   logic [7:0] left;
   logic [7:0] ul;
   logic [7:0] pred;
   logic [7:0] recon;

   logic [31:0] left_ff;
   logic [31:0] ul_ff;
   logic [23:0] gather_ff;

   assign up    = b_ctl_ff.up_ok ? rd_data : 8'd0;
   assign sh    = {b_ctl_ff.ch, 3'b000};
   assign left  = left_ff[sh +: 8];
   assign ul    = ul_ff[sh +: 8];
   assign recon = b_byte_ff + pred;
   assign wr_en = b_valid_ff && !b_ctl_ff.is_filter && !b_ctl_ff.discard && b_ctl_ff.wr_ok;

   always_comb begin
      unique case (b_ctl_ff.kind)
         psu_pkg::FILT_SUB:   pred = left;
         psu_pkg::FILT_UP:    pred = up;
         psu_pkg::FILT_AVG:   pred = 8'(({1'b0, left} + {1'b0, up}) >> 1);
         psu_pkg::FILT_PAETH: pred = psu_pkg::paeth_pred(left, up, ul);
         default:             pred = 8'd0;
      endcase
   end

   psu_line_store #(
      .DEPTH(LINE_BYTES)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept && !is_filter),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (b_addr_ff),
      .wr_data (recon)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         ul_ff     <= '0;
         gather_ff <= '0;
      end else if (b_valid_ff) begin
         if (b_ctl_ff.is_filter) begin
            left_ff   <= '0;
            ul_ff     <= '0;
            gather_ff <= '0;
         end else if (!b_ctl_ff.discard) begin
            left_ff[sh +: 8] <= recon;
            ul_ff[sh +: 8]   <= up;
            if (b_ctl_ff.pix_done) begin
               gather_ff <= '0;
            end else begin
               unique case (b_ctl_ff.ch)
                  2'd0:    gather_ff[7:0]   <= recon;
                  2'd1:    gather_ff[15:8]  <= recon;
                  2'd2:    gather_ff[23:16] <= recon;
                  default: gather_ff        <= gather_ff;
               endcase
            end
         end
      end
   end

   logic                  push;
   psu_pkg::rsp_beat_type push_beat;
   psu_pkg::rsp_beat_type out_beat;
   logic [CNT_W-1:0]      fill;

   assign push = b_valid_ff && (b_ctl_ff.is_filter ? b_ctl_ff.err
                                                   : (!b_ctl_ff.discard && b_ctl_ff.pix_done));

   always_comb begin
      if (b_ctl_ff.is_filter) begin
         push_beat.pixel = 32'd0;
         push_beat.last  = 1'b1;
         push_beat.bad   = 1'b1;
      end else begin
         push_beat.pixel = b_ctl_ff.has_alpha
            ? {recon, gather_ff[7:0], gather_ff[15:8], gather_ff[23:16]}
            : {psu_pkg::ALPHA_OPAQUE, gather_ff[7:0], gather_ff[15:8], recon};
         push_beat.last  = b_ctl_ff.last;
         push_beat.bad   = 1'b0;
      end
   end

   psu_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_beat (push_beat),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_beat  (out_beat),
      .fill      (fill)
   );

   // room for the beat in stage B plus the one being accepted
   assign req_ready = (fill + CNT_W'(b_valid_ff)) < CNT_W'(psu_pkg::OQ_DEPTH);

   assign rsp_pixel_bgra    = out_beat.pixel;
   assign rsp_last_of_image = out_beat.last;
   assign rsp_bad_filter    = out_beat.bad;

endmodule

@@ hdl/psu_checker.sv @@
// ----------------------------------------------------------------------------
// psu_checker
// Port-level checks of the scanline unfilter result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module psu_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_pixel_bgra,
   input logic        rsp_last_of_image,
   input logic        rsp_bad_filter
);

   `ASSERT_IMPL(a_bad_is_last, clock, reset, rsp_valid && rsp_bad_filter, rsp_last_of_image, "error beat without last_of_image")
   `ASSERT_IMPL(a_bad_zero_pixel, clock, reset, rsp_valid && rsp_bad_filter, rsp_pixel_bgra == 32'd0, "error beat with nonzero pixel")
   `ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pixel_bgra) && $stable(rsp_last_of_image) && $stable(rsp_bad_filter), "rsp beat changed under stall")
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "rsp valid right after reset")

endmodule

bind png_scanline_unfilter_bgra_unit psu_checker u_psu_checker (.*);
